@@ sv/sftr_pkg.sv @@
// Shared constants, codes and types for the SLIP framing transmit ring.
// Depends on nothing; the controller, datapath and top level import it.
package sftr_pkg;

    // Ring and staging geometry
    localparam int RING_DEPTH  = 128;
    localparam int STAGE_DEPTH = 255;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int STAGE_AW    = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STAGE_DEPTH + 1);
    // Worst-case frame length: every byte escaped plus two delimiters
    localparam int NEED_W      = $clog2(2 * STAGE_DEPTH + 3);

    // Operation codes
    localparam logic [2:0] OP_STAGE = 3'd0;
    localparam logic [2:0] OP_RAW   = 3'd1;
    localparam logic [2:0] OP_FRAME = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_DONE  = 3'd4;

    // SLIP special bytes
    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    // Ring write byte select
    typedef logic [1:0] t_push_sel;
    localparam t_push_sel PUSH_END  = 2'd0;
    localparam t_push_sel PUSH_ESC  = 2'd1;
    localparam t_push_sel PUSH_DATA = 2'd2;
    localparam t_push_sel PUSH_SUB  = 2'd3;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] accepted_len;
        logic       rejected;
        logic [6:0] free_space;
        logic       sending;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic      accept;
        logic      clr_res;
        logic      stage_wr;
        logic      need_init;
        logic      need_acc;
        logic      idx_clr;
        logic      idx_inc;
        logic      check;
        logic      push;
        t_push_sel push_sel;
        logic      pop;
        logic      clr_count;
        logic      load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       n_zero;
        logic       last;
        logic       is_esc;
        logic       fits;
        logic       sending;
        logic       out_busy;
    } t_sts;

endpackage

@@ sv/sftr_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module sftr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/sftr_ctrl.sv @@
// Sequencer for the SLIP transmit ring: steps each word through its operation.
// Depends on sftr_pkg; drives the datapath sftr_dp through t_cmd / t_sts.
module sftr_ctrl import sftr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_ACC = 4'd3;
    localparam logic [3:0] S_CHECK    = 4'd4;
    localparam logic [3:0] S_SOF      = 4'd5;
    localparam logic [3:0] S_COPY_RD  = 4'd6;
    localparam logic [3:0] S_COPY_WR  = 4'd7;
    localparam logic [3:0] S_COPY_ESC = 4'd8;
    localparam logic [3:0] S_EOF      = 4'd9;
    localparam logic [3:0] S_POP      = 4'd10;
    localparam logic [3:0] S_FINISH   = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       is_frame;
    logic       is_commit;

    assign is_frame  = (i_sts.op == OP_FRAME);
    assign is_commit = (i_sts.op == OP_RAW) || (i_sts.op == OP_FRAME);
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.clr_res = 1'b1;
                unique case (i_sts.op)
                    OP_STAGE: begin
                        o_cmd.stage_wr = 1'b1;
                        n_state        = S_FINISH;
                    end
                    OP_RAW: begin
                        o_cmd.need_init = 1'b1;
                        o_cmd.idx_clr   = 1'b1;
                        n_state         = S_CHECK;
                    end
                    OP_FRAME: begin
                        o_cmd.need_init = 1'b1;
                        o_cmd.idx_clr   = 1'b1;
                        n_state         = i_sts.n_zero ? S_CHECK : S_SCAN_RD;
                    end
                    OP_START: begin
                        n_state = i_sts.sending ? S_FINISH : S_POP;
                    end
                    OP_DONE: begin
                        n_state = S_POP;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_ACC;
            end
            S_SCAN_ACC: begin
                o_cmd.need_acc = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = i_sts.last ? S_CHECK : S_SCAN_RD;
            end
            S_CHECK: begin
                o_cmd.check   = 1'b1;
                o_cmd.idx_clr = 1'b1;
                priority if (!i_sts.fits) begin
                    n_state = S_FINISH;
                end else if (is_frame) begin
                    n_state = S_SOF;
                end else if (i_sts.n_zero) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_COPY_RD;
                end
            end
            S_SOF: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_END;
                n_state        = i_sts.n_zero ? S_EOF : S_COPY_RD;
            end
            S_COPY_RD: begin
                n_state = S_COPY_WR;
            end
            S_COPY_WR: begin
                o_cmd.push = 1'b1;
                if (is_frame && i_sts.is_esc) begin
                    o_cmd.push_sel = PUSH_ESC;
                    n_state        = S_COPY_ESC;
                end else begin
                    o_cmd.push_sel = PUSH_DATA;
                    o_cmd.idx_inc  = 1'b1;
                    priority if (!i_sts.last) begin
                        n_state = S_COPY_RD;
                    end else if (is_frame) begin
                        n_state = S_EOF;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_COPY_ESC: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_SUB;
                o_cmd.idx_inc  = 1'b1;
                n_state        = i_sts.last ? S_EOF : S_COPY_RD;
            end
            S_EOF: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_END;
                n_state        = S_FINISH;
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                // Drop the staged block after any commit; hold while the result is stalled
                o_cmd.clr_count = is_commit;
                o_cmd.load_out  = !i_sts.out_busy;
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/sftr_dp.sv @@
// Datapath for the SLIP transmit ring: staging store, ring store, pointers,
// length check and result register. Depends on sftr_pkg and sftr_ram.
module sftr_dp import sftr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in_item,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_out o_out_item,
    input  t_cmd i_cmd,
    output t_sts o_sts
);

    localparam int CMP_W = (NEED_W > RING_AW) ? NEED_W : RING_AW;

    logic [2:0]         r_op;
    logic [7:0]         r_data;
    logic [RING_AW-1:0] r_wr;
    logic [RING_AW-1:0] r_rd;
    logic               r_sending;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_idx;
    logic [NEED_W-1:0]  r_need;
    logic               r_txv;
    logic [7:0]         r_txb;
    logic [7:0]         r_acc;
    logic               r_rej;
    logic               r_out_valid;
    t_out               r_out;

    logic [RING_AW:0]   used_wide;
    logic [RING_AW-1:0] used;
    logic [RING_AW-1:0] free;
    logic [RING_AW-1:0] rd_pop;
    logic [RING_AW-1:0] wr_next;
    logic               ring_empty;
    logic [7:0]         stg_rdata;
    logic [7:0]         ring_rdata;
    logic [7:0]         push_byte;
    logic               stage_we;
    logic               esc;

    function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] ptr);
        logic [RING_AW-1:0] res;
        res = (ptr == RING_AW'(RING_DEPTH - 1)) ? '0 : ptr + 1'b1;
        return res;
    endfunction

    // Occupancy and free space
    always_comb begin
        if (r_wr >= r_rd) begin
            used_wide = {1'b0, r_wr} - {1'b0, r_rd};
        end else begin
            used_wide = {1'b0, r_wr} + (RING_AW + 1)'(RING_DEPTH) - {1'b0, r_rd};
        end
        used = used_wide[RING_AW-1:0];
        free = RING_AW'(RING_DEPTH - 1) - used;
    end

    assign ring_empty = (r_rd == r_wr);
    assign rd_pop     = ring_empty ? r_rd : ring_inc(r_rd);
    assign wr_next    = ring_inc(r_wr);
    assign stage_we   = i_cmd.stage_wr && (r_count < CNT_W'(STAGE_DEPTH));
    assign esc        = (stg_rdata == SLIP_END) || (stg_rdata == SLIP_ESC);

    // Select the byte written into the ring
    always_comb begin
        unique case (i_cmd.push_sel)
            PUSH_END:  push_byte = SLIP_END;
            PUSH_ESC:  push_byte = SLIP_ESC;
            PUSH_DATA: push_byte = stg_rdata;
            PUSH_SUB:  push_byte = (stg_rdata == SLIP_END) ? SLIP_ESC_END : SLIP_ESC_ESC;
            default:   push_byte = stg_rdata;
        endcase
    end

    sftr_ram #(
        .WIDTH (8),
        .DEPTH (STAGE_DEPTH)
    ) u_stage_ram (
        .i_clk   (i_clk),
        .i_we    (stage_we),
        .i_waddr (r_count[STAGE_AW-1:0]),
        .i_wdata (r_data),
        .i_raddr (r_idx[STAGE_AW-1:0]),
        .o_rdata (stg_rdata)
    );

    sftr_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_wr),
        .i_wdata (push_byte),
        .i_raddr (r_rd),
        .o_rdata (ring_rdata)
    );

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_in_item.operation;
            r_data <= i_in_item.data_byte;
        end
    end

    // Walk index and encoded length
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.need_init) begin
            r_need <= (r_op == OP_FRAME) ? NEED_W'(2) : NEED_W'(r_count);
        end else if (i_cmd.need_acc) begin
            r_need <= r_need + (esc ? NEED_W'(2) : NEED_W'(1));
        end
    end

    // Ring pointers, busy flag and staged count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= '0;
            r_rd      <= '0;
            r_sending <= 1'b0;
            r_count   <= '0;
        end else begin
            if (i_cmd.push) begin
                r_wr <= wr_next;
            end
            if (i_cmd.pop) begin
                r_rd      <= rd_pop;
                r_sending <= (rd_pop != r_wr);
            end
            if (i_cmd.clr_count) begin
                r_count <= '0;
            end else if (stage_we) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Per-word result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_res) begin
            r_txv <= 1'b0;
            r_txb <= '0;
            r_acc <= '0;
            r_rej <= 1'b0;
        end else begin
            if (i_cmd.pop && !ring_empty) begin
                r_txv <= 1'b1;
                r_txb <= ring_rdata;
            end
            if (i_cmd.check) begin
                r_acc <= o_sts.fits ? 8'(r_count) : 8'd0;
                r_rej <= !o_sts.fits;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.tx_valid     <= r_txv;
            r_out.tx_byte      <= r_txb;
            r_out.accepted_len <= r_acc;
            r_out.rejected     <= r_rej;
            r_out.free_space   <= 7'(free);
            r_out.sending      <= r_sending;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Status to the sequencer
    always_comb begin
        o_sts          = '0;
        o_sts.op       = r_op;
        o_sts.n_zero   = (r_count == '0);
        o_sts.last     = ({1'b0, r_idx} + 1'b1) == {1'b0, r_count};
        o_sts.is_esc   = esc;
        o_sts.fits     = CMP_W'(r_need) <= CMP_W'(free);
        o_sts.sending  = r_sending;
        o_sts.out_busy = r_out_valid && !i_out_ready;
    end

    // Pointers stay inside the ring
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr < RING_AW'(RING_DEPTH - 1) || r_wr == RING_AW'(RING_DEPTH - 1)) &&
        (r_rd < RING_AW'(RING_DEPTH - 1) || r_rd == RING_AW'(RING_DEPTH - 1)))
        else $error("ring pointer out of range");

    // The length check must keep every write off a full ring
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (wr_next != r_rd))
        else $error("ring written while full");

    // Staged count never passes the staging depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STAGE_DEPTH))
        else $error("staged count overflow");

    // A rejected commit reports no accepted length
    a_rej_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.rejected) |-> (r_out.accepted_len == 8'd0))
        else $error("rejected commit with a length");

endmodule

@@ sv/slip_framing_transmit_ring_top.sv @@
// Top level of the SLIP framing transmit ring: sequencer plus datapath.
// Depends on sftr_pkg, sftr_ctrl, sftr_dp (and sftr_ram via the datapath).
//
//   channel   direction  handshake                   word
//   in        sink       i_in_valid / o_in_ready     i_in_item  (t_in)
//   out       source     o_out_valid / i_out_ready   o_out_item (t_out)
//
// Each word is accepted, decoded and finished; transmit complete, and start when not
// sending, pop the ring. A commit checks its length against free space and, if it
// fits, copies staged bytes in; a frame is scanned and gets delimiters and escapes.
// Walked bytes pass an address and a use state, as both stores read registered.
// Synchronous reset clears pointers, counts and flags. A stalled result holds its
// register; the next word is taken and waits in its final step until it drains.
module slip_framing_transmit_ring_top import sftr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_item
);

    t_cmd cmd;
    t_sts sts;

    sftr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sftr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
